/* rtl/phoc_pkg.sv */
// types and constants shared by the operation cache and its testbench
package phoc_pkg;

  localparam int MAX_SLOTS = 1024;
  localparam int SLOT_AW   = $clog2(MAX_SLOTS);
  localparam int NDIV_W    = SLOT_AW + 1;

  localparam int CFG_W   = 11;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [CFG_W-1:0] TABLE_SIZE_RESET = 11'd1021;
  localparam logic             REG_TABLE_SIZE   = 1'b0;

  typedef enum logic [1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_CLEAR  = 2'd2
  } mode_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  key_tag;
    logic [31:0] key_a;
    logic [31:0] key_b;
    logic [31:0] key_c;
    logic [31:0] key_d;
    logic [31:0] value_first;
    logic [31:0] value_second;
  } in_word_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] found_first;
    logic [31:0] found_second;
  } out_word_t;

  typedef struct packed {
    logic [7:0]  tag;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [31:0] op_c;
    logic [31:0] op_d;
    logic [31:0] res_first;
    logic [31:0] res_second;
  } slot_t;

endpackage

/* rtl/phoc_ram.sv */
// generic single-write, single-read ram with registered read data
module phoc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/pairing_hash_operation_cache.sv */
// direct-mapped operation result cache indexed by a nested pairing hash
//
//  channel   direction  handshake           word
//  in        in         in_valid/in_stall   in_word   (mode, key, values)
//  out       out        out_valid/out_stall out_word  (hit, found words)
//  cfg       in/out     apb psel/penable    table_size at byte address 0
//
// lookup and insert: 4 pair steps (sum, multiply and add states) on one 32x32 multiplier,
// a bit-serial remainder, then a ram read and compare (lookup) or a ram write (insert).
// clear sweeps the ram one slot per cycle before its out_valid.
// after rst a clearing pass over all MAX_SLOTS slots runs before the first word is taken.
// in_stall stays high until the result is in the output register, so the next word is taken
// at the earliest in the cycle after that; it holds while a finished word waits on a full register.
module pairing_hash_operation_cache (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  phoc_pkg::in_word_t               in_word,
  output logic                             out_valid,
  input  logic                             out_stall,
  output phoc_pkg::out_word_t              out_word,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [phoc_pkg::PADDR_W-1:0]     paddr,
  input  logic [phoc_pkg::PDATA_W-1:0]     pwdata,
  output logic [phoc_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready
);

  typedef enum logic [8:0] {
    S_WIPE  = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_SUM   = 9'b000000100,
    S_MUL   = 9'b000001000,
    S_ADD   = 9'b000010000,
    S_DIV   = 9'b000100000,
    S_READ  = 9'b001000000,
    S_CMP   = 9'b010000000,
    S_WRITE = 9'b100000000
  } state_t;

  localparam logic [phoc_pkg::SLOT_AW-1:0] WIPE_LAST =
    phoc_pkg::SLOT_AW'(phoc_pkg::MAX_SLOTS - 1);

  state_t                           state;
  logic                             done;
  logic [phoc_pkg::CFG_W-1:0]       table_size;
  phoc_pkg::in_word_t               item;
  phoc_pkg::out_word_t              res;
  logic [phoc_pkg::NDIV_W-1:0]      n_eff;
  logic [phoc_pkg::SLOT_AW-1:0]     wipe_cnt;
  logic                             wipe_op;
  logic [1:0]                       pair_cnt;
  logic [4:0]                       div_cnt;
  logic [31:0]                      s;
  logic [31:0]                      prod;
  logic [31:0]                      h;
  logic [phoc_pkg::SLOT_AW-1:0]     rem;

  logic                             cfg_we;
  logic [31:0]                      i_sel;
  logic [31:0]                      j_sel;
  logic [31:0]                      s_inc;
  logic [31:0]                      mul_lo;
  logic [phoc_pkg::NDIV_W-1:0]      trial;
  logic [phoc_pkg::SLOT_AW-1:0]     rem_next;
  logic [31:0]                      ts32;
  logic [31:0]                      n_sat;
  logic                             match;

  logic                             ram_we;
  logic [phoc_pkg::SLOT_AW-1:0]     ram_waddr;
  phoc_pkg::slot_t                  ram_wdata;
  phoc_pkg::slot_t                  ram_rdata;

  assign pready   = 1'b1;
  assign cfg_we   = psel && penable && pwrite && (paddr[2] == phoc_pkg::REG_TABLE_SIZE);
  assign prdata   = (paddr[2] == phoc_pkg::REG_TABLE_SIZE) ? 32'(table_size) : '0;
  assign in_stall = (state != S_IDLE) || done;

  // pair(i, j) operand selection, innermost pair first
  always_comb begin
    case (pair_cnt)
      2'd0:    i_sel = item.key_c;
      2'd1:    i_sel = item.key_b;
      2'd2:    i_sel = item.key_a;
      default: i_sel = 32'(item.key_tag);
    endcase
    j_sel = (pair_cnt == 2'd0) ? item.key_d : h;
  end

  assign s_inc  = s + 32'd1;
  assign mul_lo = s * s_inc;

  assign trial    = {rem, h[div_cnt]};
  assign rem_next = (trial >= n_eff) ? phoc_pkg::SLOT_AW'(trial - n_eff)
                                     : phoc_pkg::SLOT_AW'(trial);

  always_comb begin
    ts32 = 32'(table_size);
    if (ts32 == 32'd0) begin
      n_sat = 32'd1;
    end else if (ts32 > 32'(phoc_pkg::MAX_SLOTS)) begin
      n_sat = 32'(phoc_pkg::MAX_SLOTS);
    end else begin
      n_sat = ts32;
    end
  end

  assign match = (ram_rdata.tag == item.key_tag) && (ram_rdata.op_a == item.key_a) &&
                 (ram_rdata.op_b == item.key_b) && (ram_rdata.op_c == item.key_c) &&
                 (ram_rdata.op_d == item.key_d);

  assign ram_we    = (state == S_WIPE) || (state == S_WRITE);
  assign ram_waddr = (state == S_WIPE) ? wipe_cnt : rem;
  always_comb begin
    if (state == S_WIPE) begin
      ram_wdata = '0;
    end else begin
      ram_wdata.tag        = item.key_tag;
      ram_wdata.op_a       = item.key_a;
      ram_wdata.op_b       = item.key_b;
      ram_wdata.op_c       = item.key_c;
      ram_wdata.op_d       = item.key_d;
      ram_wdata.res_first  = item.value_first;
      ram_wdata.res_second = item.value_second;
    end
  end

  phoc_ram #(
    .WIDTH ($bits(phoc_pkg::slot_t)),
    .DEPTH (phoc_pkg::MAX_SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rem),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_WIPE;
      done       <= 1'b0;
      wipe_cnt   <= '0;
      wipe_op    <= 1'b0;
      out_valid  <= 1'b0;
      table_size <= phoc_pkg::TABLE_SIZE_RESET;
      pair_cnt   <= '0;
      div_cnt    <= '0;
    end else begin
      if (cfg_we) begin
        table_size <= pwdata[phoc_pkg::CFG_W-1:0];
      end
      // hand the finished word to the output register when it is free
      if (done && (!out_valid || !out_stall)) begin
        out_word  <= res;
        out_valid <= 1'b1;
        done      <= 1'b0;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_WIPE: begin
          if (wipe_cnt == WIPE_LAST) begin
            wipe_cnt <= '0;
            state    <= S_IDLE;
            if (wipe_op) begin
              done <= 1'b1;
            end
          end else begin
            wipe_cnt <= wipe_cnt + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid && !done) begin
            item     <= in_word;
            n_eff    <= phoc_pkg::NDIV_W'(n_sat);
            pair_cnt <= '0;
            res      <= '0;
            wipe_op  <= 1'b1;
            unique case (in_word.mode) inside
              phoc_pkg::MODE_LOOKUP, phoc_pkg::MODE_INSERT: state <= S_SUM;
              phoc_pkg::MODE_CLEAR:                         state <= S_WIPE;
              default:                                      done  <= 1'b1;
            endcase
          end
        end
        S_SUM: begin
          s     <= i_sel + j_sel;
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= mul_lo;
          state <= S_ADD;
        end
        S_ADD: begin
          h <= (prod >> 1) + i_sel;
          if (pair_cnt == 2'd3) begin
            div_cnt <= 5'd31;
            rem     <= '0;
            state   <= S_DIV;
          end else begin
            pair_cnt <= pair_cnt + 2'd1;
            state    <= S_SUM;
          end
        end
        S_DIV: begin
          rem     <= rem_next;
          div_cnt <= div_cnt - 5'd1;
          if (div_cnt == 5'd0) begin
            state <= (item.mode == phoc_pkg::MODE_LOOKUP) ? S_READ : S_WRITE;
          end
        end
        S_READ: begin
          state <= S_CMP;
        end
        S_CMP: begin
          res.hit          <= match;
          res.found_first  <= ram_rdata.res_first;
          res.found_second <= ram_rdata.res_second;
          done             <= 1'b1;
          state            <= S_IDLE;
        end
        S_WRITE: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // slot index stays below the table size once the remainder is done
  a_rem_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ || state == S_WRITE) |-> (phoc_pkg::NDIV_W'(rem) < n_eff))
    else $error("slot index not below table size");

  // divisor is never zero and never above the ram depth while hashing
  a_n_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |->
      (n_eff != '0) && (n_eff <= phoc_pkg::NDIV_W'(phoc_pkg::MAX_SLOTS)))
    else $error("divisor out of range");

  // a result only appears after a word finished its work
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(done))
    else $error("result without finished word");

  // a taken word starts work or finishes at once
  a_accept_moves: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state != S_IDLE) || done)
    else $error("accepted word dropped");

  // the ram is never written during a lookup compare
  a_no_write_cmp: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ || state == S_CMP) |-> !ram_we)
    else $error("ram write during lookup");

endmodule

/* test/tb_pairing_hash_operation_cache.sv */
// testbench for the pairing hash operation cache: predicted cache contents, randomized traffic
`timescale 1ns / 1ps

module tb_pairing_hash_operation_cache;

  localparam logic [1:0]                   MODE_UNUSED     = 2'd3;
  localparam logic [phoc_pkg::PADDR_W-1:0] TABLE_SIZE_ADDR =
    phoc_pkg::PADDR_W'(4 * phoc_pkg::REG_TABLE_SIZE);
  localparam int                           LONG_HOLD       = 600;
  localparam int                           DRAIN_CYCLES    = 60;
  localparam int                           PHASES          = 10;
  localparam int                           PHASE_ITEMS     = 100;
  localparam int                           POOL_DEPTH      = 12;

  class op_cache_predictor;
    phoc_pkg::slot_t            slots [phoc_pkg::MAX_SLOTS];
    logic [phoc_pkg::CFG_W-1:0] table_size;
    phoc_pkg::out_word_t        expected_words [$];
    int                         errors;

    function new();
      table_size = phoc_pkg::TABLE_SIZE_RESET;
      foreach (slots[i]) slots[i] = '0;
      errors = 0;
    endfunction

    function logic [31:0] pair(logic [31:0] i, logic [31:0] j);
      logic [31:0] s;
      logic [31:0] t;
      logic [31:0] p;
      s = i + j;
      t = s + 32'd1;
      p = s * t;
      return (p >> 1) + i;
    endfunction

    function int unsigned slot_index(phoc_pkg::in_word_t w);
      logic [31:0] h;
      int unsigned n;
      h = pair({24'd0, w.key_tag}, pair(w.key_a, pair(w.key_b, pair(w.key_c, w.key_d))));
      n = table_size;
      if (n == 0) n = 1;
      if (n > phoc_pkg::MAX_SLOTS) n = phoc_pkg::MAX_SLOTS;
      return h % n;
    endfunction

    function void set_table_size(logic [phoc_pkg::CFG_W-1:0] v);
      table_size = v;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void accept_word(phoc_pkg::in_word_t w);
      phoc_pkg::out_word_t r;
      int unsigned         k;
      r = '0;
      case (w.mode)
        phoc_pkg::MODE_LOOKUP: begin
          k = slot_index(w);
          r.hit = (slots[k].tag == w.key_tag) && (slots[k].op_a == w.key_a) &&
                  (slots[k].op_b == w.key_b) && (slots[k].op_c == w.key_c) &&
                  (slots[k].op_d == w.key_d);
          r.found_first  = slots[k].res_first;
          r.found_second = slots[k].res_second;
        end
        phoc_pkg::MODE_INSERT: begin
          k = slot_index(w);
          slots[k].tag        = w.key_tag;
          slots[k].op_a       = w.key_a;
          slots[k].op_b       = w.key_b;
          slots[k].op_c       = w.key_c;
          slots[k].op_d       = w.key_d;
          slots[k].res_first  = w.value_first;
          slots[k].res_second = w.value_second;
        end
        phoc_pkg::MODE_CLEAR: begin
          foreach (slots[i]) slots[i] = '0;
        end
        default: ;
      endcase
      expected_words.push_back(r);
    endfunction

    function void check_word(phoc_pkg::out_word_t got);
      phoc_pkg::out_word_t want;
      if (expected_words.size() == 0) begin
        $error("result word with none expected: hit %0b found_first %h found_second %h",
               got.hit, got.found_first, got.found_second);
        errors++;
        return;
      end
      want = expected_words.pop_front();
      if (got.hit !== want.hit) begin
        $error("hit: expected %0b, actual %0b", want.hit, got.hit);
        errors++;
      end
      if (got.found_first !== want.found_first) begin
        $error("found_first: expected %h, actual %h", want.found_first, got.found_first);
        errors++;
      end
      if (got.found_second !== want.found_second) begin
        $error("found_second: expected %h, actual %h", want.found_second, got.found_second);
        errors++;
      end
    endfunction
  endclass

  logic                         clk;
  logic                         rst;
  logic                         in_valid;
  logic                         in_stall;
  phoc_pkg::in_word_t           in_word;
  logic                         out_valid;
  logic                         out_stall;
  phoc_pkg::out_word_t          out_word;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [phoc_pkg::PADDR_W-1:0] paddr;
  logic [phoc_pkg::PDATA_W-1:0] pwdata;
  logic [phoc_pkg::PDATA_W-1:0] prdata;
  logic                         pready;

  op_cache_predictor  board;
  phoc_pkg::in_word_t key_pool [$];
  bit                 calm;
  bit                 hold_request;

  pairing_hash_operation_cache DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50000000;
    $display("FAIL pairing_hash_operation_cache");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) board.accept_word(in_word);
    if (!rst && out_valid && !out_stall) board.check_word(out_word);
  end

  // result side: stall bursts at a rate that changes now and then, plus one long hold-off
  initial begin : receiver
    int unsigned stall_pct;
    int unsigned since_change;
    out_stall    = 1'b0;
    stall_pct    = 0;
    since_change = 0;
    forever begin
      @(negedge clk);
      since_change++;
      if (since_change >= 50) begin
        since_change = 0;
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 5;
          default: stall_pct = 25;
        endcase
      end
      if (hold_request) begin
        out_stall = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        hold_request = 1'b0;
        out_stall    = 1'b0;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 9)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  function automatic phoc_pkg::in_word_t make_word(logic [1:0] mode, logic [7:0] tag,
                                                   logic [31:0] a, logic [31:0] b,
                                                   logic [31:0] c, logic [31:0] d,
                                                   logic [31:0] first,
                                                   logic [31:0] second);
    phoc_pkg::in_word_t w;
    w.mode         = mode;
    w.key_tag      = tag;
    w.key_a        = a;
    w.key_b        = b;
    w.key_c        = c;
    w.key_d        = d;
    w.value_first  = first;
    w.value_second = second;
    return w;
  endfunction

  function automatic logic [31:0] random_operand();
    case ($urandom_range(0, 3))
      0: return 32'($urandom_range(0, 7));
      1: return 32'hFFFF_FFFF - 32'($urandom_range(0, 7));
      default: return $urandom;
    endcase
  endfunction

  function automatic phoc_pkg::in_word_t random_key(logic [1:0] mode);
    logic [7:0] tag;
    tag = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
    return make_word(mode, tag, random_operand(), random_operand(), random_operand(),
                     random_operand(), $urandom, $urandom);
  endfunction

  // mostly inserts and lookups of recent keys, so that hits are common
  function automatic phoc_pkg::in_word_t random_item();
    phoc_pkg::in_word_t w;
    int unsigned        pick;
    pick = $urandom_range(0, 199);
    w    = random_key(phoc_pkg::MODE_LOOKUP);
    if (pick < 70) begin
      if (key_pool.size() != 0 && $urandom_range(0, 3) == 0)
        w = key_pool[$urandom_range(0, key_pool.size() - 1)];
      w.mode         = phoc_pkg::MODE_INSERT;
      w.value_first  = $urandom;
      w.value_second = $urandom;
      key_pool.push_back(w);
      if (key_pool.size() > POOL_DEPTH) void'(key_pool.pop_front());
    end else if (pick < 170 && key_pool.size() != 0) begin
      w              = key_pool[$urandom_range(0, key_pool.size() - 1)];
      w.mode         = phoc_pkg::MODE_LOOKUP;
      w.value_first  = $urandom;
      w.value_second = $urandom;
      if (pick >= 150) begin
        case ($urandom_range(0, 4))
          0: w.key_tag = w.key_tag ^ (8'd1 << $urandom_range(0, 7));
          1: w.key_a   = w.key_a ^ (32'd1 << $urandom_range(0, 31));
          2: w.key_b   = w.key_b ^ (32'd1 << $urandom_range(0, 31));
          3: w.key_c   = w.key_c ^ (32'd1 << $urandom_range(0, 31));
          default: w.key_d = w.key_d ^ (32'd1 << $urandom_range(0, 31));
        endcase
      end
    end else if (pick < 180) begin
      w = make_word(phoc_pkg::MODE_LOOKUP, 8'd0, '0, '0, '0, '0, $urandom, $urandom);
    end else if (pick < 194) begin
      w.mode = (pick < 188) ? phoc_pkg::MODE_LOOKUP : MODE_UNUSED;
    end else if (pick < 197) begin
      w.mode = phoc_pkg::MODE_CLEAR;
    end
    return w;
  endfunction

  task automatic send_word(phoc_pkg::in_word_t w);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_word  = w;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apb_access(bit wr, logic [phoc_pkg::PDATA_W-1:0] wdata,
                            output logic [phoc_pkg::PDATA_W-1:0] rdata);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = TABLE_SIZE_ADDR;
    pwdata  = wdata;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic check_table_size();
    logic [phoc_pkg::PDATA_W-1:0] rd;
    apb_access(1'b0, '0, rd);
    if (rd[phoc_pkg::CFG_W-1:0] !== board.table_size) begin
      $error("table_size: expected %0d, actual %0d", board.table_size,
             rd[phoc_pkg::CFG_W-1:0]);
      board.errors++;
    end
  endtask

  task automatic write_table_size(logic [phoc_pkg::CFG_W-1:0] v);
    logic [phoc_pkg::PDATA_W-1:0] rd;
    in_valid = 1'b0;
    while (board.pending() != 0) @(negedge clk);
    apb_access(1'b1, phoc_pkg::PDATA_W'(v), rd);
    board.set_table_size(v);
    check_table_size();
  endtask

  initial begin : stimulus
    phoc_pkg::in_word_t         k1;
    phoc_pkg::in_word_t         ones;
    phoc_pkg::in_word_t         zero_key;
    logic [phoc_pkg::CFG_W-1:0] sizes [PHASES];
    board        = new();
    rst          = 1'b1;
    in_valid     = 1'b0;
    in_word      = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    calm         = 1'b0;
    hold_request = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    check_table_size();

    ones     = make_word(phoc_pkg::MODE_LOOKUP, 8'hFF, '1, '1, '1, '1, '1, '0);
    zero_key = make_word(phoc_pkg::MODE_LOOKUP, 8'h00, '0, '0, '0, '0, '0, '0);
    k1       = random_key(phoc_pkg::MODE_LOOKUP);

    // zeroed entries hit an all-zero key
    send_word(zero_key);
    send_word(ones);
    ones.mode = phoc_pkg::MODE_INSERT;
    send_word(ones);
    ones.mode = phoc_pkg::MODE_LOOKUP;
    send_word(ones);
    k1.mode = phoc_pkg::MODE_INSERT;
    send_word(k1);
    k1.mode = phoc_pkg::MODE_LOOKUP;
    send_word(k1);
    send_word(make_word(phoc_pkg::MODE_LOOKUP, k1.key_tag ^ 8'h01, k1.key_a, k1.key_b,
                        k1.key_c, k1.key_d, '0, '0));
    send_word(make_word(MODE_UNUSED, 8'hFF, '1, '1, '1, '1, '1, '1));
    send_word(k1);
    send_word(make_word(phoc_pkg::MODE_CLEAR, 8'hFF, '1, '1, '1, '1, '1, '1));
    send_word(ones);
    send_word(zero_key);

    // zero size folds every key onto one slot
    write_table_size('0);
    k1.mode = phoc_pkg::MODE_INSERT;
    send_word(k1);
    k1.mode = phoc_pkg::MODE_LOOKUP;
    send_word(ones);
    send_word(make_word(phoc_pkg::MODE_LOOKUP, k1.key_tag, k1.key_a, k1.key_b, k1.key_c,
                        ~k1.key_d, '0, '0));
    send_word(k1);
    send_word(make_word(phoc_pkg::MODE_INSERT, 8'h00, '0, '0, '0, '0, '1, '1));
    send_word(zero_key);

    // oversized table saturates
    write_table_size('1);
    send_word(k1);
    ones.mode = phoc_pkg::MODE_INSERT;
    send_word(ones);
    ones.mode = phoc_pkg::MODE_LOOKUP;
    send_word(ones);
    send_word(make_word(phoc_pkg::MODE_CLEAR, '0, '0, '0, '0, '0, '0, '0));

    sizes = '{11'd2, 11'd1024, 11'd7, 11'd2047, 11'd0, 11'd13, 11'd97, 11'd1021, 11'd0, 11'd0};
    sizes[PHASES-2] = phoc_pkg::CFG_W'($urandom_range(2, 1024));
    sizes[PHASES-1] = phoc_pkg::CFG_W'($urandom_range(0, 2047));

    for (int p = 0; p < PHASES; p++) begin
      write_table_size(sizes[p]);
      if (p == PHASES - 1) calm = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 2 && n == 30) hold_request = 1'b1;
        send_word(random_item());
      end
    end

    in_valid = 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (board.errors == 0 && board.pending() == 0)
      $display("PASS pairing_hash_operation_cache");
    else
      $display("FAIL pairing_hash_operation_cache");
    $finish;
  end

endmodule
